@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rasterizer rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/blr_pkg.sv @@
// shared types and constants for the bresenham line rasterizer
// no dependencies
package blr_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int COLOR_WIDTH     = 24;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } blr_cmd_t;

endpackage

@@ rtl/core/bresenham_line_rasterizer_core.sv @@
// Bresenham line rasterizer, all octants. A load command (s_tuser = 0) takes both endpoints
// and a color and returns the start pixel; each step command (s_tuser = 1) returns the next
// pixel, with m_tlast high on the endpoint. A step with no line in progress returns nothing,
// and a load always abandons the line in progress. The block takes one transaction per clock
// and returns one pixel per clock while m_tready stays high: a transaction is held in the
// input register, the decision term and coordinates update in a single add-and-compare pass,
// and the pixel is then captured in the output register and offered on m_tvalid.
// depends on blr_pkg and assert_macros.svh
`include "assert_macros.svh"

module bresenham_line_rasterizer_core
    import blr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int S_DATA_W   = ((4 * COORD_WIDTH + COLOR_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * COORD_WIDTH + COLOR_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // x_start, y_start, x_end, y_end, line_color, zero pad (lowest bit first)
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad (lowest bit first)
    output logic [M_DATA_W-1:0] m_tdata,
    // last_pixel
    output logic                m_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int EW     = CW + 3;
    localparam int IN_W   = 4 * CW + COLOR_WIDTH;

    // input register
    logic                   in_valid_reg, in_valid_next;
    blr_cmd_t               in_cmd_reg;
    logic [IN_W-1:0]        in_data_reg;

    // line state
    logic [CW-1:0]          cur_x_reg, cur_x_next;
    logic [CW-1:0]          cur_y_reg, cur_y_next;
    logic signed [EW-1:0]   err_reg, err_next;
    logic [DW-1:0]          tmaj_reg, tmaj_next;
    logic [DW-1:0]          tmin_reg, tmin_next;
    logic                   x_neg_reg, x_neg_next;
    logic                   y_neg_reg, y_neg_next;
    logic                   x_major_reg, x_major_next;
    logic [CW-1:0]          left_reg, left_next;
    logic [COLOR_WIDTH-1:0] color_reg, color_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [CW-1:0]          m_x_reg;
    logic [CW-1:0]          m_y_reg;
    logic [COLOR_WIDTH-1:0] m_color_reg;
    logic                   m_last_reg;

    logic                   s_accept;
    logic                   proc_fire;
    logic                   is_load;
    logic                   line_active;
    logic                   emit;
    logic                   emit_last;

    logic [CW-1:0]          xs, ys, xe, ye;
    logic [COLOR_WIDTH-1:0] ld_color;
    logic                   ld_x_neg, ld_y_neg, ld_x_major;
    logic [CW-1:0]          adx, ady, ld_maj, ld_min;
    logic signed [EW-1:0]   maj_e, min_e, ld_err_init, ld_err_a, ld_err_b;
    logic signed [EW-1:0]   st_tmaj_e, st_tmin_e, st_err_a;

    logic [CW-1:0]          base_x, base_y;
    logic                   base_x_neg, base_y_neg, base_x_major, minor_move;
    logic                   x_moves, y_moves;

    assign s_accept  = s_tvalid && s_tready;
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    assign is_load     = (in_cmd_reg == CMD_LOAD);
    assign line_active = (left_reg != '0);
    assign emit        = is_load || line_active;

    // unpack the held transaction
    assign xs       = in_data_reg[0 +: CW];
    assign ys       = in_data_reg[CW +: CW];
    assign xe       = in_data_reg[2*CW +: CW];
    assign ye       = in_data_reg[3*CW +: CW];
    assign ld_color = in_data_reg[4*CW +: COLOR_WIDTH];

    // load: deltas, major axis and the term after the first pixel
    always_comb begin
        ld_x_neg   = (xe < xs);
        ld_y_neg   = (ye < ys);
        adx        = ld_x_neg ? (xs - xe) : (xe - xs);
        ady        = ld_y_neg ? (ys - ye) : (ye - ys);
        ld_x_major = (adx > ady);
        ld_maj     = ld_x_major ? adx : ady;
        ld_min     = ld_x_major ? ady : adx;
        maj_e      = signed'({3'b000, ld_maj});
        min_e      = signed'({3'b000, ld_min});
        ld_err_init = (min_e <<< 1) - maj_e;
        // both outcomes of the first decision worked out side by side
        ld_err_a   = (min_e <<< 2) - maj_e;
        ld_err_b   = ld_err_a - (maj_e <<< 1);
    end

    // step: term update from the stored doubled deltas
    always_comb begin
        st_tmaj_e = signed'({2'b00, tmaj_reg});
        st_tmin_e = signed'({2'b00, tmin_reg});
        st_err_a  = err_reg + st_tmin_e;
    end

    // next-point selection shared by load and step
    always_comb begin
        if (is_load) begin
            base_x       = xs;
            base_y       = ys;
            base_x_neg   = ld_x_neg;
            base_y_neg   = ld_y_neg;
            base_x_major = ld_x_major;
            minor_move   = !ld_err_init[EW-1];
        end else begin
            base_x       = cur_x_reg;
            base_y       = cur_y_reg;
            base_x_neg   = x_neg_reg;
            base_y_neg   = y_neg_reg;
            base_x_major = x_major_reg;
            minor_move   = !err_reg[EW-1];
        end
        x_moves = base_x_major || minor_move;
        y_moves = !base_x_major || minor_move;
    end

    always_comb begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        tmaj_next    = tmaj_reg;
        tmin_next    = tmin_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        left_next    = left_reg;
        color_next   = color_reg;
        emit_last    = is_load ? (ld_maj == '0) : (left_reg == CW'(1));

        if (proc_fire && emit) begin
            if (x_moves) begin
                cur_x_next = base_x_neg ? (base_x - CW'(1)) : (base_x + CW'(1));
            end else begin
                cur_x_next = base_x;
            end
            if (y_moves) begin
                cur_y_next = base_y_neg ? (base_y - CW'(1)) : (base_y + CW'(1));
            end else begin
                cur_y_next = base_y;
            end

            if (is_load) begin
                err_next     = minor_move ? ld_err_b : ld_err_a;
                tmaj_next    = {ld_maj, 1'b0};
                tmin_next    = {ld_min, 1'b0};
                x_neg_next   = ld_x_neg;
                y_neg_next   = ld_y_neg;
                x_major_next = ld_x_major;
                left_next    = ld_maj;
                color_next   = ld_color;
            end else begin
                err_next  = minor_move ? (st_err_a - st_tmaj_e) : st_err_a;
                left_next = left_reg - CW'(1);
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (proc_fire) begin
            m_valid_next = emit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            left_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            left_reg     <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg  <= blr_cmd_t'(s_tuser);
            in_data_reg <= s_tdata[IN_W-1:0];
        end
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        err_reg     <= err_next;
        tmaj_reg    <= tmaj_next;
        tmin_reg    <= tmin_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
        x_major_reg <= x_major_next;
        color_reg   <= color_next;
        if (proc_fire && emit) begin
            m_x_reg     <= base_x;
            m_y_reg     <= base_y;
            m_color_reg <= is_load ? ld_color : color_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        m_tdata                          = '0;
        m_tdata[0 +: CW]                 = m_x_reg;
        m_tdata[CW +: CW]                = m_y_reg;
        m_tdata[2*CW +: COLOR_WIDTH]     = m_color_reg;
    end

    // a step with no line in progress leaves the output empty
    `ASSERT_NEXT(a_idle_step_silent, aclk, aresetn, proc_fire && !emit, !m_valid_reg)
    // every load yields a pixel
    `ASSERT_NEXT(a_load_emits, aclk, aresetn, proc_fire && is_load, m_valid_reg)
    // the endpoint pixel ends the line
    `ASSERT_NEXT(a_last_ends_line, aclk, aresetn, proc_fire && emit && emit_last, left_reg == '0)
    // a pixel short of the endpoint keeps the line going
    `ASSERT_NEXT(a_mid_keeps_line, aclk, aresetn, proc_fire && emit && !emit_last, left_reg != '0)

endmodule
